// File: sv/acs_pkg.sv
`default_nettype none

package acs_pkg;

   localparam int unsigned PC_W        = 13;
   localparam int unsigned WORD_W      = 16;
   localparam int unsigned LOAD_ADDR_W = 12;
   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned FIELD_W     = 12;
   localparam int unsigned OPC_W       = 4;
   localparam int unsigned ALU_SEL_W   = 2;

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_STEP = 1'b1;

   localparam logic [OPC_W-1:0] OP_ADD_ABS = 4'd0;
   localparam logic [OPC_W-1:0] OP_ADD_IND = 4'd1;
   localparam logic [OPC_W-1:0] OP_JUMP    = 4'd2;
   localparam logic [OPC_W-1:0] OP_END     = 4'd3;

   localparam logic [ALU_SEL_W-1:0] ALU_INC_PC  = 2'd0;
   localparam logic [ALU_SEL_W-1:0] ALU_INC_MAR = 2'd1;
   localparam logic [ALU_SEL_W-1:0] ALU_STEP_PC = 2'd2;
   localparam logic [ALU_SEL_W-1:0] ALU_ACC     = 2'd3;

   typedef struct packed {
      logic [ALU_SEL_W-1:0] sel;
      logic [PC_W-1:0]      pc;
      logic [WORD_W-1:0]    mar;
      logic [WORD_W-1:0]    ac;
      logic [WORD_W-1:0]    x;
   } acs_alu_in_type;

endpackage

`default_nettype wire

// File: sv/acs_if.sv
`default_nettype none

interface acs_req_if import acs_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic                   opcode;
   logic [LOAD_ADDR_W-1:0] load_address;
   logic [BYTE_W-1:0]      load_byte;

   modport source (output valid, opcode, load_address, load_byte, input ready);
   modport sink   (input valid, opcode, load_address, load_byte, output ready);
endinterface

interface acs_rsp_if import acs_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [PC_W-1:0]   program_counter;
   logic [WORD_W-1:0] instruction_reg;
   logic [WORD_W-1:0] address_reg;
   logic [WORD_W-1:0] data_reg;
   logic [WORD_W-1:0] operand_reg;
   logic [WORD_W-1:0] accumulator;
   logic              halted;

   modport source (output valid, program_counter, instruction_reg, address_reg, data_reg,
                   operand_reg, accumulator, halted, input ready);
   modport sink   (input valid, program_counter, instruction_reg, address_reg, data_reg,
                   operand_reg, accumulator, halted, output ready);
endinterface

`default_nettype wire

// File: sv/accumulator_cpu_step_top.sv
// Accumulator processor with a byte memory of 2**MEM_ADDR_BITS entries behind one
// port and one shared 16-bit adder under a sequencer. A load transaction (opcode 0)
// writes one byte and completes in the cycle it is accepted, with no response. A step
// transaction (opcode 1) executes one instruction and returns one response with all
// registers and the halted flag. Memory reads give registered data, and the adder
// serves address increments, PC advance and the accumulator add in turn; a step taken
// while halted goes straight to the response. The block takes a new transaction in
// the cycle after the response is taken. Memory contents are undefined until loaded;
// executing from unloaded bytes gives undefined results.
`default_nettype none

module accumulator_cpu_step_top import acs_pkg::*; #(
   parameter int unsigned MEM_ADDR_BITS = 12,
   parameter int unsigned PROGRAM_LIMIT = 1024
) (
   input  wire logic  clock,
   input  wire logic  reset,
   acs_req_if.sink    req_ch,
   acs_rsp_if.source  rsp_ch
);

   localparam logic [PC_W-1:0] PC_LIMIT = PC_W'(PROGRAM_LIMIT);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_F0   = 4'd1;
   localparam logic [3:0] S_F1   = 4'd2;
   localparam logic [3:0] S_DEC  = 4'd3;
   localparam logic [3:0] S_P0   = 4'd4;
   localparam logic [3:0] S_P1   = 4'd5;
   localparam logic [3:0] S_P2   = 4'd6;
   localparam logic [3:0] S_A0   = 4'd7;
   localparam logic [3:0] S_A1   = 4'd8;
   localparam logic [3:0] S_A2   = 4'd9;
   localparam logic [3:0] S_ADD  = 4'd10;
   localparam logic [3:0] S_PCI  = 4'd11;
   localparam logic [3:0] S_CHK  = 4'd12;
   localparam logic [3:0] S_RSP  = 4'd13;

   logic [3:0]        state_ff, state_in;
   logic [PC_W-1:0]   pc_ff, pc_in;
   logic [WORD_W-1:0] ir_ff, ir_in;
   logic [WORD_W-1:0] mar_ff, mar_in;
   logic [WORD_W-1:0] mdr_ff, mdr_in;
   logic [WORD_W-1:0] x_ff, x_in;
   logic [WORD_W-1:0] ac_ff, ac_in;
   logic              halt_ff, halt_in;
   logic [BYTE_W-1:0] lo_ff, lo_in;

   logic                     mem_we;
   logic [WORD_W-1:0]        addr_word;
   logic [MEM_ADDR_BITS-1:0] mem_addr;
   logic [BYTE_W-1:0]        mem_rdata;
   logic [WORD_W-1:0]        rd_word;
   logic [OPC_W-1:0]         rd_op;
   acs_alu_in_type           alu_in;
   logic [WORD_W-1:0]        alu_sum;
   logic                     req_fire;

   assign req_fire = req_ch.valid && req_ch.ready;
   assign mem_we   = req_fire && (req_ch.opcode == REQ_LOAD);
   assign rd_word  = {mem_rdata, lo_ff};
   assign rd_op    = rd_word[WORD_W-1 -: OPC_W];

   always_comb begin
      alu_in.pc  = pc_ff;
      alu_in.mar = mar_ff;
      alu_in.ac  = ac_ff;
      alu_in.x   = x_ff;
      case (state_ff)
         S_P1, S_A1: alu_in.sel = ALU_INC_MAR;
         S_ADD:      alu_in.sel = ALU_ACC;
         S_PCI:      alu_in.sel = ALU_STEP_PC;
         default:    alu_in.sel = ALU_INC_PC;
      endcase
   end

   acs_alu u_alu (
      .alu_in (alu_in),
      .sum    (alu_sum)
   );

   always_comb begin
      case (state_ff)
         S_IDLE:           addr_word = {{(WORD_W-LOAD_ADDR_W){1'b0}}, req_ch.load_address};
         S_F0:             addr_word = {{(WORD_W-PC_W){1'b0}}, pc_ff};
         S_P0, S_A0:       addr_word = mar_ff;
         S_F1, S_P1, S_A1: addr_word = alu_sum;
         default:          addr_word = '0;
      endcase
   end

   assign mem_addr = addr_word[MEM_ADDR_BITS-1:0];

   acs_mem #(
      .ADDR_W (MEM_ADDR_BITS)
   ) u_mem (
      .clock    (clock),
      .we       (mem_we),
      .addr     (mem_addr),
      .wdata    (req_ch.load_byte),
      .rdata_ff (mem_rdata)
   );

   always_comb begin
      state_in = state_ff;
      pc_in    = pc_ff;
      ir_in    = ir_ff;
      mar_in   = mar_ff;
      mdr_in   = mdr_ff;
      x_in     = x_ff;
      ac_in    = ac_ff;
      halt_in  = halt_ff;
      lo_in    = lo_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire && (req_ch.opcode == REQ_STEP)) begin
               state_in = halt_ff ? S_RSP : S_F0;
            end
         end
         S_F0: state_in = S_F1;
         S_F1: begin
            lo_in    = mem_rdata;
            state_in = S_DEC;
         end
         S_DEC: begin
            ir_in = rd_word;
            case (rd_op)
               OP_ADD_ABS: begin
                  mar_in   = {{(WORD_W-FIELD_W){1'b0}}, rd_word[FIELD_W-1:0]};
                  state_in = S_A0;
               end
               OP_ADD_IND: begin
                  mar_in   = {{(WORD_W-FIELD_W){1'b0}}, rd_word[FIELD_W-1:0]};
                  state_in = S_P0;
               end
               OP_JUMP: begin
                  pc_in    = {rd_word[FIELD_W-1:0], 1'b0};
                  state_in = S_CHK;
               end
               OP_END: begin
                  halt_in  = 1'b1;
                  state_in = S_PCI;
               end
               default: state_in = S_PCI;
            endcase
         end
         S_P0: state_in = S_P1;
         S_P1: begin
            lo_in    = mem_rdata;
            state_in = S_P2;
         end
         S_P2: begin
            mdr_in   = rd_word;
            mar_in   = rd_word;
            state_in = S_A0;
         end
         S_A0: state_in = S_A1;
         S_A1: begin
            lo_in    = mem_rdata;
            state_in = S_A2;
         end
         S_A2: begin
            mdr_in   = rd_word;
            x_in     = rd_word;
            state_in = S_ADD;
         end
         S_ADD: begin
            ac_in    = alu_sum;
            state_in = S_PCI;
         end
         S_PCI: begin
            pc_in    = alu_sum[PC_W-1:0];
            state_in = S_CHK;
         end
         S_CHK: begin
            if (pc_ff >= PC_LIMIT) begin
               halt_in = 1'b1;
            end
            state_in = S_RSP;
         end
         S_RSP: begin
            if (rsp_ch.ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pc_ff    <= '0;
         ir_ff    <= '0;
         mar_ff   <= '0;
         mdr_ff   <= '0;
         x_ff     <= '0;
         ac_ff    <= '0;
         halt_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         ir_ff    <= ir_in;
         mar_ff   <= mar_in;
         mdr_ff   <= mdr_in;
         x_ff     <= x_in;
         ac_ff    <= ac_in;
         halt_ff  <= halt_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff <= lo_in;
   end

   assign req_ch.ready           = (state_ff == S_IDLE);
   assign rsp_ch.valid           = (state_ff == S_RSP);
   assign rsp_ch.program_counter = pc_ff;
   assign rsp_ch.instruction_reg = ir_ff;
   assign rsp_ch.address_reg     = mar_ff;
   assign rsp_ch.data_reg        = mdr_ff;
   assign rsp_ch.operand_reg     = x_ff;
   assign rsp_ch.accumulator     = ac_ff;
   assign rsp_ch.halted          = halt_ff;

endmodule

`default_nettype wire

// File: sv/acs_mem.sv
`default_nettype none

module acs_mem import acs_pkg::*; #(
   parameter int unsigned ADDR_W = 12
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] addr,
   input  wire logic [BYTE_W-1:0] wdata,
   output logic      [BYTE_W-1:0] rdata_ff
);

   localparam int unsigned DEPTH = 1 << ADDR_W;

   logic [BYTE_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

endmodule

`default_nettype wire

// File: sv/acs_alu.sv
`default_nettype none

module acs_alu import acs_pkg::*; (
   input  wire acs_alu_in_type    alu_in,
   output logic [WORD_W-1:0]      sum
);

   logic [WORD_W-1:0] op_a;
   logic [WORD_W-1:0] op_b;
   logic [WORD_W-1:0] pc_ext;

   assign pc_ext = {{(WORD_W-PC_W){1'b0}}, alu_in.pc};

   always_comb begin
      case (alu_in.sel)
         ALU_INC_PC: begin
            op_a = pc_ext;
            op_b = WORD_W'(1);
         end
         ALU_INC_MAR: begin
            op_a = alu_in.mar;
            op_b = WORD_W'(1);
         end
         ALU_STEP_PC: begin
            op_a = pc_ext;
            op_b = WORD_W'(2);
         end
         ALU_ACC: begin
            op_a = alu_in.ac;
            op_b = alu_in.x;
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   assign sum = op_a + op_b;

endmodule

`default_nettype wire

// File: sv/acs_checker.sv
`default_nettype none

module acs_checker import acs_pkg::*; (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              req_opcode,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic              rsp_halted,
   input wire logic [PC_W-1:0]   rsp_program_counter,
   input wire logic [WORD_W-1:0] rsp_accumulator
);

   logic req_fire;

   assign req_fire = req_valid && req_ready;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_program_counter)
         && $stable(rsp_accumulator) && $stable(rsp_halted))
      else $error("response changed while stalled");

   a_busy_after_step: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_opcode == REQ_STEP) |=> !req_ready)
      else $error("request taken while a step is in progress");

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request ready while a response is pending");

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> !$fell(rsp_halted))
      else $error("halted flag cleared without reset");

endmodule

bind accumulator_cpu_step_top acs_checker u_acs_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_ch.valid),
   .req_ready           (req_ch.ready),
   .req_opcode          (req_ch.opcode),
   .rsp_valid           (rsp_ch.valid),
   .rsp_ready           (rsp_ch.ready),
   .rsp_halted          (rsp_ch.halted),
   .rsp_program_counter (rsp_ch.program_counter),
   .rsp_accumulator     (rsp_ch.accumulator)
);

`default_nettype wire

// File: tb/tb_accumulator_cpu_step_top.sv
`timescale 1ns / 1ps

module tb_accumulator_cpu_step_top;
   import acs_pkg::*;

   localparam int unsigned MEM_BYTES     = 4096;
   localparam int unsigned PROGRAM_LIMIT = 1024;
   localparam int unsigned JUMP_SPAN     = PROGRAM_LIMIT / 2;
   localparam int unsigned RANDOM_ITEMS  = 550;
   localparam int unsigned DRAIN_CYCLES  = 30;
   localparam int unsigned CYCLE_LIMIT   = 1000000;
   localparam int unsigned PRINT_LIMIT   = 200;

   localparam logic [OPC_W-1:0] OP_NOP_FIRST = 4'd4;
   localparam logic [OPC_W-1:0] OP_NOP_LAST  = 4'd15;

   typedef struct packed {
      logic [PC_W-1:0]   pc;
      logic [WORD_W-1:0] ir;
      logic [WORD_W-1:0] mar;
      logic [WORD_W-1:0] mdr;
      logic [WORD_W-1:0] x;
      logic [WORD_W-1:0] ac;
      logic              halt;
   } cpu_regs_type;

   typedef enum int unsigned {
      HALT_BY_END,
      HALT_BY_FAR_JUMP,
      HALT_BY_LIMIT
   } halt_route_type;

   logic clock;
   logic reset;

   acs_req_if req_ch ();
   acs_rsp_if rsp_ch ();

   accumulator_cpu_step_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   logic [BYTE_W-1:0] shadow_mem [MEM_BYTES];
   bit                byte_loaded [MEM_BYTES];
   cpu_regs_type      cpu_regs = '0;
   cpu_regs_type      expected_regs [$];
   int unsigned       mismatch_count = 0;
   int unsigned       items_sent = 0;
   int unsigned       cycle_count = 0;
   bit                sender_idling = 1'b1;
   bit                receiver_idling = 1'b1;

   initial begin
      clock = 1'b0;
   end

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT) begin
         $display("[%0t] MISMATCH %s", $time, msg);
      end
   endtask

   function automatic logic [WORD_W-1:0] mem_word(input logic [WORD_W-1:0] addr);
      logic [LOAD_ADDR_W-1:0] lo_addr;
      logic [LOAD_ADDR_W-1:0] hi_addr;
      lo_addr = addr[LOAD_ADDR_W-1:0];
      hi_addr = lo_addr + 12'd1;
      return {shadow_mem[hi_addr], shadow_mem[lo_addr]};
   endfunction

   task automatic execute_instruction();
      logic [OPC_W-1:0] op;
      logic             jumped;
      jumped = 1'b0;
      if (!cpu_regs.halt) begin
         cpu_regs.ir = mem_word({3'b000, cpu_regs.pc});
         op = cpu_regs.ir[WORD_W-1 -: OPC_W];
         if (op == OP_ADD_ABS || op == OP_ADD_IND) begin
            cpu_regs.mar = {4'h0, cpu_regs.ir[FIELD_W-1:0]};
            if (op == OP_ADD_IND) begin
               cpu_regs.mdr = mem_word(cpu_regs.mar);
               cpu_regs.mar = cpu_regs.mdr;
            end
            cpu_regs.mdr = mem_word(cpu_regs.mar);
            cpu_regs.x   = cpu_regs.mdr;
            cpu_regs.ac  = cpu_regs.ac + cpu_regs.x;
         end else if (op == OP_JUMP) begin
            cpu_regs.pc = {cpu_regs.ir[FIELD_W-1:0], 1'b0};
            jumped = 1'b1;
         end else if (op == OP_END) begin
            cpu_regs.halt = 1'b1;
         end
         if (!jumped) begin
            cpu_regs.pc = cpu_regs.pc + 13'd2;
         end
         if (cpu_regs.pc >= PROGRAM_LIMIT) begin
            cpu_regs.halt = 1'b1;
         end
      end
      expected_regs.push_back(cpu_regs);
   endtask

   task automatic send_item(input logic op, input logic [LOAD_ADDR_W-1:0] addr,
                            input logic [BYTE_W-1:0] data);
      if (sender_idling && $urandom_range(0, 4) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.opcode       <= op;
      req_ch.load_address <= addr;
      req_ch.load_byte    <= data;
      do @(posedge clock); while (!req_ch.ready);
      if (op == REQ_LOAD) begin
         shadow_mem[addr]  = data;
         byte_loaded[addr] = 1'b1;
      end else begin
         execute_instruction();
      end
      items_sent++;
   endtask

   task automatic write_word(input logic [LOAD_ADDR_W-1:0] addr, input logic [WORD_W-1:0] word);
      send_item(REQ_LOAD, addr, word[7:0]);
      send_item(REQ_LOAD, addr + 12'd1, word[15:8]);
   endtask

   // load random bytes wherever the next step would read unwritten memory
   task automatic fill_word(input logic [LOAD_ADDR_W-1:0] addr);
      logic [LOAD_ADDR_W-1:0] hi_addr;
      hi_addr = addr + 12'd1;
      if (!byte_loaded[addr]) begin
         send_item(REQ_LOAD, addr, BYTE_W'($urandom_range(0, 255)));
      end
      if (!byte_loaded[hi_addr]) begin
         send_item(REQ_LOAD, hi_addr, BYTE_W'($urandom_range(0, 255)));
      end
   endtask

   task automatic step_cpu();
      logic [WORD_W-1:0] word;
      logic [WORD_W-1:0] pointer;
      if (!cpu_regs.halt) begin
         fill_word(cpu_regs.pc[LOAD_ADDR_W-1:0]);
         word = mem_word({3'b000, cpu_regs.pc});
         if (word[WORD_W-1 -: OPC_W] == OP_ADD_ABS || word[WORD_W-1 -: OPC_W] == OP_ADD_IND) begin
            fill_word(word[FIELD_W-1:0]);
         end
         if (word[WORD_W-1 -: OPC_W] == OP_ADD_IND) begin
            pointer = mem_word({4'h0, word[FIELD_W-1:0]});
            fill_word(pointer[LOAD_ADDR_W-1:0]);
         end
      end
      send_item(REQ_STEP, LOAD_ADDR_W'($urandom_range(0, 4095)),
                BYTE_W'($urandom_range(0, 255)));
   endtask

   function automatic bit instruction_safe(input logic [PC_W-1:0] pc);
      logic [LOAD_ADDR_W-1:0] hi_addr;
      logic [WORD_W-1:0]      word;
      logic [OPC_W-1:0]       op;
      hi_addr = pc[LOAD_ADDR_W-1:0] + 12'd1;
      if (!byte_loaded[pc[LOAD_ADDR_W-1:0]] || !byte_loaded[hi_addr]) begin
         return 1'b0;
      end
      word = mem_word({3'b000, pc});
      op   = word[WORD_W-1 -: OPC_W];
      if (op == OP_END) begin
         return 1'b0;
      end
      if (op == OP_JUMP && word[FIELD_W-1:0] >= JUMP_SPAN) begin
         return 1'b0;
      end
      return !(pc == PROGRAM_LIMIT - 2 && op != OP_JUMP);
   endfunction

   function automatic logic [WORD_W-1:0] random_instruction(input logic [PC_W-1:0] pc);
      int unsigned       kind;
      logic [FIELD_W-1:0] field;
      logic [OPC_W-1:0]   nop_code;
      kind     = $urandom_range(0, 9);
      field    = FIELD_W'($urandom_range(0, 4095));
      nop_code = OPC_W'($urandom_range(OP_NOP_FIRST, OP_NOP_LAST));
      if (pc == PROGRAM_LIMIT - 2) begin
         kind = 6;
      end
      if (kind < 3) begin
         return {OP_ADD_ABS, field};
      end
      if (kind < 6) begin
         return {OP_ADD_IND, field};
      end
      if (kind < 8) begin
         return {OP_JUMP, 3'b000, field[8:0]};
      end
      return {nop_code, field};
   endfunction

   task automatic test_add_absolute_wrap();
      write_word(12'h000, {OP_ADD_ABS, 12'hFFF});
      send_item(REQ_LOAD, 12'hFFF, 8'hFF);
      step_cpu();
   endtask

   task automatic test_add_indirect_pointer();
      write_word(12'h002, {OP_ADD_IND, 12'h800});
      write_word(12'h800, 16'hFFFE);
      send_item(REQ_LOAD, 12'hFFE, 8'h02);
      step_cpu();
   endtask

   task automatic test_no_op_codes();
      write_word(12'h004, {OP_NOP_FIRST, 12'hABC});
      write_word(12'h006, {OP_NOP_LAST, 12'h000});
      step_cpu();
      step_cpu();
   endtask

   task automatic test_jump_back();
      write_word(12'h008, {OP_JUMP, 12'h000});
      step_cpu();
      step_cpu();
   endtask

   task automatic test_random_program();
      int unsigned start;
      int unsigned pass_count;
      int unsigned choice;
      start      = items_sent;
      pass_count = 0;
      while (items_sent - start < RANDOM_ITEMS) begin
         if (items_sent - start > RANDOM_ITEMS * 4 / 5) begin
            sender_idling   = 1'b0;
            receiver_idling = 1'b0;
         end else if (pass_count % 40 == 0) begin
            sender_idling   = 1'($urandom_range(0, 1));
            receiver_idling = 1'($urandom_range(0, 1));
         end
         choice = $urandom_range(0, 99);
         if (choice < 10) begin
            send_item(REQ_LOAD, LOAD_ADDR_W'($urandom_range(0, 4095)),
                      BYTE_W'($urandom_range(0, 255)));
         end else if (choice < 14) begin
            // break the instruction at PC with a stray byte
            send_item(REQ_LOAD,
                      cpu_regs.pc[LOAD_ADDR_W-1:0] + LOAD_ADDR_W'($urandom_range(0, 1)),
                      BYTE_W'($urandom_range(0, 255)));
         end else begin
            if (!instruction_safe(cpu_regs.pc) || $urandom_range(0, 2) == 0) begin
               write_word(cpu_regs.pc[LOAD_ADDR_W-1:0], random_instruction(cpu_regs.pc));
            end
            step_cpu();
         end
         pass_count++;
      end
   endtask

   task automatic test_halt_and_hold();
      logic [LOAD_ADDR_W-1:0] pc_addr;
      halt_route_type         route;
      sender_idling   = 1'b0;
      receiver_idling = 1'b0;
      pc_addr = cpu_regs.pc[LOAD_ADDR_W-1:0];
      route   = halt_route_type'($urandom_range(0, 2));
      case (route)
         HALT_BY_END: begin
            write_word(pc_addr, {OP_END, 12'h000});
            step_cpu();
         end
         HALT_BY_FAR_JUMP: begin
            write_word(pc_addr, {OP_JUMP, 12'hFFF});
            step_cpu();
         end
         default: begin
            write_word(pc_addr, {OP_JUMP, 12'h1FF});
            step_cpu();
            write_word(12'h3FE, {OP_NOP_LAST, 12'hFFF});
            step_cpu();
         end
      endcase
      step_cpu();
      step_cpu();
      send_item(REQ_LOAD, pc_addr, BYTE_W'($urandom_range(0, 255)));
      step_cpu();
   endtask

   always @(posedge clock) begin : check_responses
      cpu_regs_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_regs.size() == 0) begin
            report_mismatch("response transaction with nothing expected");
         end else begin
            want = expected_regs.pop_front();
            if (rsp_ch.program_counter !== want.pc) begin
               report_mismatch($sformatf("program_counter got %h expected %h",
                                         rsp_ch.program_counter, want.pc));
            end
            if (rsp_ch.instruction_reg !== want.ir) begin
               report_mismatch($sformatf("instruction_reg got %h expected %h",
                                         rsp_ch.instruction_reg, want.ir));
            end
            if (rsp_ch.address_reg !== want.mar) begin
               report_mismatch($sformatf("address_reg got %h expected %h",
                                         rsp_ch.address_reg, want.mar));
            end
            if (rsp_ch.data_reg !== want.mdr) begin
               report_mismatch($sformatf("data_reg got %h expected %h",
                                         rsp_ch.data_reg, want.mdr));
            end
            if (rsp_ch.operand_reg !== want.x) begin
               report_mismatch($sformatf("operand_reg got %h expected %h",
                                         rsp_ch.operand_reg, want.x));
            end
            if (rsp_ch.accumulator !== want.ac) begin
               report_mismatch($sformatf("accumulator got %h expected %h",
                                         rsp_ch.accumulator, want.ac));
            end
            if (rsp_ch.halted !== want.halt) begin
               report_mismatch($sformatf("halted got %b expected %b",
                                         rsp_ch.halted, want.halt));
            end
         end
      end
   end

   initial begin
      rsp_ch.ready <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(posedge clock);
         if (receiver_idling && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("accumulator_cpu_step_top test failed");
      $finish;
   end

   initial begin
      reset               <= 1'b1;
      req_ch.valid        <= 1'b0;
      req_ch.opcode       <= REQ_LOAD;
      req_ch.load_address <= '0;
      req_ch.load_byte    <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_add_absolute_wrap();
      test_add_indirect_pointer();
      test_no_op_codes();
      test_jump_back();
      test_random_program();
      test_halt_and_hold();

      req_ch.valid <= 1'b0;
      while (expected_regs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("accumulator_cpu_step_top test passed");
      end else begin
         $display("accumulator_cpu_step_top test failed");
      end
      $finish;
   end

endmodule
